>>> design/lla_pkg.sv
// Shared constants, codes and request/response types for the life-like automaton block.
`timescale 1ns / 1ps
package lla_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_AW     = $clog2(MAX_ROWS);
   localparam int COL_AW     = $clog2(MAX_COLS);
   localparam int ROW_CW     = $clog2(MAX_ROWS + 1);
   localparam int COL_CW     = $clog2(MAX_COLS + 1);
   localparam int GEN_CW     = $clog2(MAX_ROWS + 2);
   localparam int MOD_W      = (ROW_CW > COL_CW) ? ROW_CW : COL_CW;
   localparam int COORD_W    = 8;
   localparam int WRAP_CNT_W = $clog2(COORD_W + 1);
   localparam int SIZE_W     = 7;
   localparam int MASK_W     = 9;
   localparam int GEN_W      = 32;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 9;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COL_COUNT    = 2'd1,
      CSR_BIRTH_MASK   = 2'd2,
      CSR_SURVIVE_MASK = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                    op;
      logic signed [COORD_W-1:0] row;
      logic signed [COORD_W-1:0] col;
      logic                      alive;
   } req_type;

   typedef struct packed {
      logic             cell_alive;
      logic [GEN_W-1:0] generation;
      logic             range_error;
   } rsp_type;

   typedef struct packed {
      logic                en;
      logic [ROW_AW-1:0]   addr;
      logic [MAX_COLS-1:0] data;
   } grid_wr_type;

   typedef struct packed {
      logic              en;
      logic [ROW_AW-1:0] addr;
   } grid_rd_type;

endpackage

>>> design/life_like_automaton_torus.sv
// Top level of the life-like cellular automaton on a wrapping grid.
//
// Requests enter on req_data with start; one is taken when start is high and busy is low.
// Each request gives exactly one response on rsp_data, marked by rsp_valid for one cycle;
// the receiver cannot stall it, and busy drops in the same cycle the response shows.
// Steps until rsp_valid, by request kind:
//   write in range: row read, then modified row written; out-of-range write or unused op: none,
//   read: the shared-nothing bit-serial row/column wrap units, then a memory read,
//   generation: the last row, then each active row, read in order and each row written once,
//   with two row buffers and a saved copy of row 0 closing the wrap.
// The csr_ port writes row_count, col_count, birth_mask and survive_mask; it is always
// ready and is to be written only while no request is in flight.
// Reset clears the grid (per-row valid bits), the generation count and the registers to
// 64 rows, 64 columns, birth mask 8 and survival mask 12; the block is usable at once.
`timescale 1ns / 1ps
module life_like_automaton_torus (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lla_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output lla_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lla_pkg::csr_index_type        csr_index,
   input  logic [lla_pkg::CSR_DW-1:0]    csr_wdata
);
   import lla_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_WR_MOD   = 6'b000010,
      ST_WRAP     = 6'b000100,
      ST_RD_WAIT  = 6'b001000,
      ST_GEN      = 6'b010000,
      ST_GEN_LAST = 6'b100000
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [SIZE_W-1:0]   row_count_ff;
   logic [SIZE_W-1:0]   col_count_ff;
   logic [MASK_W-1:0]   birth_mask_ff;
   logic [MASK_W-1:0]   survive_mask_ff;
   logic [GEN_W-1:0]    gen_count_ff;
   logic [GEN_W-1:0]    gen_count_in;
   req_type             req_ff;
   logic [COL_AW-1:0]   col_sel_ff;
   logic [GEN_CW-1:0]   rd_k_ff;
   logic [GEN_CW-1:0]   dk_ff;
   logic                dv_ff;
   logic [MAX_COLS-1:0] p1_ff;
   logic [MAX_COLS-1:0] p2_ff;
   logic [MAX_COLS-1:0] row0_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   logic [ROW_CW-1:0]   act_rows;
   logic [COL_CW-1:0]   act_cols;
   logic [ROW_AW-1:0]   last_row;
   logic                wr_ok;
   logic                accept;
   logic                gen_rd_en;
   logic [ROW_AW-1:0]   gen_addr;
   grid_wr_type         wr;
   grid_rd_type         rd;
   logic [MAX_COLS-1:0] rd_data;
   logic [MAX_COLS-1:0] row_mod;
   logic [MAX_COLS-1:0] rule_below;
   logic [MAX_COLS-1:0] rule_next;
   logic                wrap_start;
   logic                row_done;
   logic                col_done;
   logic [MOD_W-1:0]    row_wrapped;
   logic [MOD_W-1:0]    col_wrapped;

   assign act_rows = (row_count_ff == '0) ? ROW_CW'(1) :
                     (int'(row_count_ff) > MAX_ROWS) ? ROW_CW'(MAX_ROWS) :
                     ROW_CW'(row_count_ff);
   assign act_cols = (col_count_ff == '0) ? COL_CW'(1) :
                     (int'(col_count_ff) > MAX_COLS) ? COL_CW'(MAX_COLS) :
                     COL_CW'(col_count_ff);
   assign last_row = ROW_AW'(act_rows - ROW_CW'(1));
   assign wr_ok    = !req_data.row[COORD_W-1] && !req_data.col[COORD_W-1]
                     && (int'(req_data.row) < int'(act_rows))
                     && (int'(req_data.col) < int'(act_cols));
   assign accept    = start && (state_ff == ST_IDLE);
   assign gen_rd_en = (int'(rd_k_ff) <= int'(act_rows));
   assign gen_addr  = (rd_k_ff == '0) ? last_row : ROW_AW'(rd_k_ff - GEN_CW'(1));

   lla_grid_mem u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   lla_wrap u_row_wrap (
      .clock   (clock),
      .reset   (reset),
      .start   (wrap_start),
      .value   (req_data.row),
      .modulus (MOD_W'(act_rows)),
      .done    (row_done),
      .result  (row_wrapped)
   );

   lla_wrap u_col_wrap (
      .clock   (clock),
      .reset   (reset),
      .start   (wrap_start),
      .value   (req_data.col),
      .modulus (MOD_W'(act_cols)),
      .done    (col_done),
      .result  (col_wrapped)
   );

   lla_row_rule u_row_rule (
      .above        (p2_ff),
      .cur          (p1_ff),
      .below        (rule_below),
      .act_cols     (act_cols),
      .birth_mask   (birth_mask_ff),
      .survive_mask (survive_mask_ff),
      .next_row     (rule_next)
   );

   always_comb begin
      state_in     = state_ff;
      rd           = '0;
      wr           = '0;
      wrap_start   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      gen_count_in = gen_count_ff;
      rule_below   = rd_data;
      row_mod      = rd_data;
      row_mod[COL_AW'(req_ff.col)] = req_ff.alive;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in.cell_alive  = 1'b0;
               rsp_data_in.generation  = gen_count_ff;
               rsp_data_in.range_error = 1'b0;
               unique case (req_data.op)
                  OP_WRITE: begin
                     if (wr_ok) begin
                        rd.en    = 1'b1;
                        rd.addr  = ROW_AW'(req_data.row);
                        state_in = ST_WR_MOD;
                     end else begin
                        rsp_valid_in            = 1'b1;
                        rsp_data_in.range_error = 1'b1;
                     end
                  end
                  OP_READ: begin
                     wrap_start = 1'b1;
                     state_in   = ST_WRAP;
                  end
                  OP_STEP: begin
                     state_in = ST_GEN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WR_MOD: begin
            wr.en                  = 1'b1;
            wr.addr                = ROW_AW'(req_ff.row);
            wr.data                = row_mod;
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_alive = req_ff.alive;
            state_in               = ST_IDLE;
         end
         ST_WRAP: begin
            if (row_done && col_done) begin
               rd.en    = 1'b1;
               rd.addr  = ROW_AW'(row_wrapped);
               state_in = ST_RD_WAIT;
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_alive = rd_data[col_sel_ff];
            state_in               = ST_IDLE;
         end
         ST_GEN: begin
            rd.en   = gen_rd_en;
            rd.addr = gen_addr;
            if (dv_ff) begin
               if (dk_ff >= GEN_CW'(2)) begin
                  wr.en   = 1'b1;
                  wr.addr = ROW_AW'(dk_ff - GEN_CW'(2));
                  wr.data = rule_next;
               end
               if (int'(dk_ff) == int'(act_rows)) begin
                  state_in = ST_GEN_LAST;
               end
            end
         end
         ST_GEN_LAST: begin
            rule_below             = row0_ff;
            wr.en                  = 1'b1;
            wr.addr                = last_row;
            wr.data                = rule_next;
            gen_count_in           = gen_count_ff + GEN_W'(1);
            rsp_valid_in           = 1'b1;
            rsp_data_in.generation = gen_count_in;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         gen_count_ff    <= '0;
         row_count_ff    <= SIZE_W'(64);
         col_count_ff    <= SIZE_W'(64);
         birth_mask_ff   <= MASK_W'(8);
         survive_mask_ff <= MASK_W'(12);
         rd_k_ff         <= '0;
         dv_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_count_ff <= gen_count_in;
         dv_ff        <= (state_ff == ST_GEN) && gen_rd_en;
         if (accept) begin
            rd_k_ff <= '0;
         end else if ((state_ff == ST_GEN) && gen_rd_en) begin
            rd_k_ff <= rd_k_ff + GEN_CW'(1);
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ROW_COUNT:    row_count_ff    <= SIZE_W'(csr_wdata);
               CSR_COL_COUNT:    col_count_ff    <= SIZE_W'(csr_wdata);
               CSR_BIRTH_MASK:   birth_mask_ff   <= MASK_W'(csr_wdata);
               CSR_SURVIVE_MASK: survive_mask_ff <= MASK_W'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      dk_ff       <= rd_k_ff;
      if (accept) begin
         req_ff <= req_data;
      end
      if ((state_ff == ST_WRAP) && row_done) begin
         col_sel_ff <= COL_AW'(col_wrapped);
      end
      if ((state_ff == ST_GEN) && dv_ff) begin
         p2_ff <= p1_ff;
         p1_ff <= rd_data;
         if (dk_ff == GEN_CW'(1)) begin
            row0_ff <= rd_data;
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while a request is still in flight");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither in flight nor answered");

   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (int'(wr.addr) < int'(act_rows)))
      else $error("grid row write outside active rows");

   a_gen_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$stable(gen_count_ff) |-> (rsp_valid && (rsp_data.generation == gen_count_ff)))
      else $error("generation count moved without a matching response");

endmodule

>>> design/lla_grid_mem.sv
// Cell grid row memory: one write port, one registered read port, per-row valid bits.
`timescale 1ns / 1ps
module lla_grid_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  lla_pkg::grid_wr_type         wr,
   input  lla_pkg::grid_rd_type         rd,
   output logic [lla_pkg::MAX_COLS-1:0] rd_data
);
   import lla_pkg::*;

   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic [MAX_COLS-1:0] rd_raw_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         grid_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_raw_ff <= grid_mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= row_valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

>>> design/lla_wrap.sv
// Iterative signed-coordinate wrap unit: restoring remainder, one bit per cycle.
`timescale 1ns / 1ps
module lla_wrap (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [lla_pkg::COORD_W-1:0] value,
   input  logic [lla_pkg::MOD_W-1:0]         modulus,
   output logic                              done,
   output logic [lla_pkg::MOD_W-1:0]         result
);
   import lla_pkg::*;

   logic [COORD_W-1:0]    mag_ff;
   logic [COORD_W-1:0]    mag_in;
   logic                  neg_ff;
   logic [MOD_W-1:0]      rem_ff;
   logic [MOD_W-1:0]      rem_in;
   logic [MOD_W:0]        shifted;
   logic [WRAP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   always_comb begin
      shifted = {rem_ff, mag_ff[COORD_W-1]};
      if (shifted >= {1'b0, modulus}) begin
         rem_in = MOD_W'(shifted - {1'b0, modulus});
      end else begin
         rem_in = MOD_W'(shifted);
      end
      mag_in = value[COORD_W-1] ? COORD_W'(-value) : COORD_W'(value);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag_in;
         neg_ff <= value[COORD_W-1];
         rem_ff <= '0;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[COORD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= WRAP_CNT_W'(COORD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - WRAP_CNT_W'(1);
            if (cnt_ff == WRAP_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = (neg_ff && (rem_ff != '0)) ? MOD_W'(modulus - rem_ff) : rem_ff;

endmodule

>>> design/lla_row_rule.sv
// Next-generation rule for one grid row from its old row and the two wrapped neighbor rows.
`timescale 1ns / 1ps
module lla_row_rule (
   input  logic [lla_pkg::MAX_COLS-1:0] above,
   input  logic [lla_pkg::MAX_COLS-1:0] cur,
   input  logic [lla_pkg::MAX_COLS-1:0] below,
   input  logic [lla_pkg::COL_CW-1:0]   act_cols,
   input  logic [lla_pkg::MASK_W-1:0]   birth_mask,
   input  logic [lla_pkg::MASK_W-1:0]   survive_mask,
   output logic [lla_pkg::MAX_COLS-1:0] next_row
);
   import lla_pkg::*;

   logic [COL_AW-1:0]   last_col;
   logic [MAX_COLS-1:0] above_l;
   logic [MAX_COLS-1:0] above_r;
   logic [MAX_COLS-1:0] cur_l;
   logic [MAX_COLS-1:0] cur_r;
   logic [MAX_COLS-1:0] below_l;
   logic [MAX_COLS-1:0] below_r;
   logic [MAX_COLS-1:0] al;
   logic [MAX_COLS-1:0] ar;
   logic [MAX_COLS-1:0] cl;
   logic [MAX_COLS-1:0] cr;
   logic [MAX_COLS-1:0] bl;
   logic [MAX_COLS-1:0] br;
   logic [3:0]          nb_cnt [MAX_COLS];

   assign last_col = COL_AW'(act_cols - COL_CW'(1));
   assign above_l  = {above[MAX_COLS-2:0], above[MAX_COLS-1]};
   assign above_r  = {above[0], above[MAX_COLS-1:1]};
   assign cur_l    = {cur[MAX_COLS-2:0], cur[MAX_COLS-1]};
   assign cur_r    = {cur[0], cur[MAX_COLS-1:1]};
   assign below_l  = {below[MAX_COLS-2:0], below[MAX_COLS-1]};
   assign below_r  = {below[0], below[MAX_COLS-1:1]};

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         al[c] = (c == 0) ? above[last_col] : above_l[c];
         cl[c] = (c == 0) ? cur[last_col]   : cur_l[c];
         bl[c] = (c == 0) ? below[last_col] : below_l[c];
         ar[c] = (int'(last_col) == c) ? above[0] : above_r[c];
         cr[c] = (int'(last_col) == c) ? cur[0]   : cur_r[c];
         br[c] = (int'(last_col) == c) ? below[0] : below_r[c];
         nb_cnt[c] = 4'(al[c]) + 4'(above[c]) + 4'(ar[c]) + 4'(cl[c]) + 4'(cr[c])
                   + 4'(bl[c]) + 4'(below[c]) + 4'(br[c]);
         if (c < int'(act_cols)) begin
            next_row[c] = cur[c] ? survive_mask[nb_cnt[c]] : birth_mask[nb_cnt[c]];
         end else begin
            next_row[c] = cur[c];
         end
      end
   end

endmodule
